[rtl/mecanum_frame_rotate_mix_core_macros.svh]
// assertion macros for the mecanum frame rotate and mix core
// expects clk and arst_n in the scope where the macros are used
`ifndef MECANUM_FRAME_ROTATE_MIX_CORE_MACROS_SVH
`define MECANUM_FRAME_ROTATE_MIX_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define MFRM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mfrm assertion failed");
`define MFRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfrm assertion failed");
`else
`define MFRM_ASSERT(label, prop)
`define MFRM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/mfrm_pkg.sv]
// shared types and constants of the mecanum frame rotate and mix core
// register map, config struct, cordic angle table; no dependencies
`timescale 1ns / 1ps

package mfrm_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_START = 652032874;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef enum logic [1:0] {
		REG_YAW_OFFSET,
		REG_SPEED_GAIN,
		REG_TURN_ARM,
		REG_WHEEL_RECIP
	} reg_idx_t;

	localparam logic [12:0] RST_YAW_OFFSET  = 13'd290;
	localparam logic [3:0]  RST_SPEED_GAIN  = 4'd3;
	localparam logic [15:0] RST_TURN_ARM    = 16'd256;
	localparam logic [15:0] RST_WHEEL_RECIP = 16'd256;

	typedef struct packed {
		logic [12:0] yaw_offset;
		logic [3:0]  speed_gain;
		logic [15:0] turn_arm_scale;
		logic [15:0] wheel_factor_recip;
	} cfg_t;

	// width of the rounded chassis-frame x and y terms (q.8)
	function automatic int rot_xw(int sw, int tfb);
		int gw;
		gw = sw + tfb + 2 + 1 + 5;
		return gw - (tfb - 8) + 1;
	endfunction

	// width of the turn term g*rot*arm (q.8)
	function automatic int rot_ww(int sw);
		return sw + 5 + 17;
	endfunction

endpackage

[rtl/mfrm_cordic.sv]
// pipelined cordic: folds the half turn, one rotation step per stage, rounds
// sine and cosine to q.TRIG_FRACTION_BITS; uses mfrm_pkg
`timescale 1ns / 1ps

module mfrm_cordic #(
	parameter int ANGLE_BITS = 13,
	parameter int TRIG_FRACTION_BITS = 15,
	parameter int SIDE_W = 48,
	localparam int TW = TRIG_FRACTION_BITS + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ANGLE_BITS-1:0] in_angle,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [TW-1:0] out_cos,
	output logic signed [TW-1:0] out_sin,
	output logic [SIDE_W-1:0]    out_side
);
	import mfrm_pkg::*;

	localparam int XW = 33;
	localparam int NS = CORDIC_STEPS + 3;
	localparam int SA = CORDIC_STEPS + 1;
	localparam int SB = CORDIC_STEPS + 2;
	localparam int RSH = 30 - TRIG_FRACTION_BITS;
	localparam int MW = TRIG_FRACTION_BITS + 1;
	localparam logic [XW-1:0] HALF = XW'(1) << (RSH - 1);

	logic [NS-1:0] v_s;
	logic [NS:0]   en;

	logic signed [XW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] y_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] z_s [0:CORDIC_STEPS];
	logic                 flip_s [0:CORDIC_STEPS];
	logic [SIDE_W-1:0]    side_s [0:NS-1];

	logic [MW-1:0] cmag_s31, smag_s31;
	logic          cneg_s31, sneg_s31;
	logic signed [TW-1:0] cos_s32, sin_s32;

	logic [31:0]   turn;
	logic [31:0]   turn_f;
	logic          flip_in;
	logic [XW-1:0] ax, ay, csum, ssum;

	assign turn    = {in_angle, {(32 - ANGLE_BITS){1'b0}}};
	assign flip_in = turn[31] ^ turn[30];
	assign turn_f  = {turn[31] ^ flip_in, turn[30:0]};

	assign en[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = !v_s[k] || en[k+1];
	end
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s[0]    <= XW'(CORDIC_START);
			y_s[0]    <= '0;
			z_s[0]    <= {turn_f[31], turn_f};
			flip_s[0] <= flip_in;
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XW-1:0] xsh, ysh, ang;
		assign xsh = x_s[i] >>> i;
		assign ysh = y_s[i] >>> i;
		assign ang = XW'(ATAN_TURNS[i]);

		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				if (!z_s[i][XW-1]) begin
					x_s[i+1] <= x_s[i] - ysh;
					y_s[i+1] <= y_s[i] + xsh;
					z_s[i+1] <= z_s[i] - ang;
				end else begin
					x_s[i+1] <= x_s[i] + ysh;
					y_s[i+1] <= y_s[i] - xsh;
					z_s[i+1] <= z_s[i] + ang;
				end
				flip_s[i+1] <= flip_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	// round half away from zero on the magnitude
	assign ax   = x_s[CORDIC_STEPS][XW-1] ? XW'(-x_s[CORDIC_STEPS]) : XW'(x_s[CORDIC_STEPS]);
	assign ay   = y_s[CORDIC_STEPS][XW-1] ? XW'(-y_s[CORDIC_STEPS]) : XW'(y_s[CORDIC_STEPS]);
	assign csum = ax + HALF;
	assign ssum = ay + HALF;

	always_ff @(posedge clk) begin
		if (en[SA]) begin
			cmag_s31   <= csum[RSH +: MW];
			smag_s31   <= ssum[RSH +: MW];
			cneg_s31   <= x_s[CORDIC_STEPS][XW-1] ^ flip_s[CORDIC_STEPS];
			sneg_s31   <= y_s[CORDIC_STEPS][XW-1] ^ flip_s[CORDIC_STEPS];
			side_s[SA] <= side_s[CORDIC_STEPS];
		end
		if (en[SB]) begin
			cos_s32    <= cneg_s31 ? -$signed({1'b0, cmag_s31}) : $signed({1'b0, cmag_s31});
			sin_s32    <= sneg_s31 ? -$signed({1'b0, smag_s31}) : $signed({1'b0, smag_s31});
			side_s[SB] <= side_s[SA];
		end
	end

	assign out_valid = v_s[SB];
	assign out_cos   = cos_s32;
	assign out_sin   = sin_s32;
	assign out_side  = side_s[SB];

endmodule

[rtl/mfrm_rotate.sv]
// gimbal to chassis frame rotation: products, sums, gain, rounding to q.8
// and the turn term g*rot*arm; uses mfrm_pkg
`timescale 1ns / 1ps

module mfrm_rotate #(
	parameter int SPEED_WIDTH = 16,
	parameter int TRIG_FRACTION_BITS = 15,
	localparam int TW = TRIG_FRACTION_BITS + 2,
	localparam int XW = mfrm_pkg::rot_xw(SPEED_WIDTH, TRIG_FRACTION_BITS),
	localparam int WW = mfrm_pkg::rot_ww(SPEED_WIDTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mfrm_pkg::cfg_t           cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [TW-1:0]     in_cos,
	input  logic signed [TW-1:0]     in_sin,
	input  logic [3*SPEED_WIDTH-1:0] in_side,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [XW-1:0]     out_x,
	output logic signed [XW-1:0]     out_y,
	output logic signed [WW-1:0]     out_w
);
	import mfrm_pkg::*;

	localparam int SW  = SPEED_WIDTH;
	localparam int PRW = SW + TW;
	localparam int GRW = SW + 5;
	localparam int GW  = PRW + 1 + 5;
	localparam int RS  = TRIG_FRACTION_BITS - 8;
	localparam int MXW = GW - RS;
	localparam logic [GW-1:0] HALF = (GW'(1) << RS) >> 1;

	logic [5:1] v_s;
	logic [6:1] en;

	logic signed [SW-1:0] vx, vy, rot;
	logic signed [4:0]    g;

	logic signed [PRW-1:0] pxc_s1, pys_s1, pxs_s1, pyc_s1;
	logic signed [GRW-1:0] gr_s1;
	logic signed [PRW:0]   sx_s2, sy_s2;
	logic signed [WW-1:0]  w_s2, w_s3, w_s4, w_s5;
	logic signed [GW-1:0]  gx_s3, gy_s3;
	logic [MXW-1:0]        xm_s4, ym_s4;
	logic                  xn_s4, yn_s4;
	logic signed [XW-1:0]  x_s5, y_s5;
	logic [GW-1:0]         ax, ay, xsum, ysum;

	assign vx  = $signed(in_side[0 +: SW]);
	assign vy  = $signed(in_side[SW +: SW]);
	assign rot = $signed(in_side[2*SW +: SW]);
	assign g   = $signed({1'b0, cfg.speed_gain});

	assign en[6] = out_ready;
	for (genvar k = 1; k <= 5; k++) begin : g_en
		assign en[k] = !v_s[k] || en[k+1];
	end
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1]) v_s[1] <= in_valid;
			for (int k = 2; k <= 5; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	assign ax   = gx_s3[GW-1] ? GW'(-gx_s3) : GW'(gx_s3);
	assign ay   = gy_s3[GW-1] ? GW'(-gy_s3) : GW'(gy_s3);
	assign xsum = ax + HALF;
	assign ysum = ay + HALF;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pxc_s1 <= vx * in_cos;
			pys_s1 <= vy * in_sin;
			pxs_s1 <= vx * in_sin;
			pyc_s1 <= vy * in_cos;
			gr_s1  <= g * rot;
		end
		if (en[2]) begin
			sx_s2 <= pys_s1 - pxc_s1;
			sy_s2 <= pxs_s1 + pyc_s1;
			w_s2  <= gr_s1 * $signed({1'b0, cfg.turn_arm_scale});
		end
		if (en[3]) begin
			gx_s3 <= g * sx_s2;
			gy_s3 <= g * sy_s2;
			w_s3  <= w_s2;
		end
		if (en[4]) begin
			xm_s4 <= xsum[GW-1:RS];
			ym_s4 <= ysum[GW-1:RS];
			xn_s4 <= gx_s3[GW-1];
			yn_s4 <= gy_s3[GW-1];
			w_s4  <= w_s3;
		end
		if (en[5]) begin
			x_s5 <= xn_s4 ? -$signed({1'b0, xm_s4}) : $signed({1'b0, xm_s4});
			y_s5 <= yn_s4 ? -$signed({1'b0, ym_s4}) : $signed({1'b0, ym_s4});
			w_s5 <= w_s4;
		end
	end

	assign out_valid = v_s[5];
	assign out_x     = x_s5;
	assign out_y     = y_s5;
	assign out_w     = w_s5;

endmodule

[rtl/mfrm_mix.sv]
// mecanum wheel mixing: four signed sums, reciprocal scaling with rounding,
// saturation to SPEED_WIDTH; output register of the core; uses mfrm_pkg
`timescale 1ns / 1ps

module mfrm_mix #(
	parameter int SPEED_WIDTH = 16,
	parameter int XW = 33,
	parameter int WW = 38
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mfrm_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [XW-1:0]          in_x,
	input  logic signed [XW-1:0]          in_y,
	input  logic signed [WW-1:0]          in_w,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SPEED_WIDTH-1:0] out_wheel0,
	output logic signed [SPEED_WIDTH-1:0] out_wheel1,
	output logic signed [SPEED_WIDTH-1:0] out_wheel2,
	output logic signed [SPEED_WIDTH-1:0] out_wheel3
);
	import mfrm_pkg::*;

	localparam int SW = SPEED_WIDTH;
	localparam int PW = ((XW > WW) ? XW : WW) + 2;
	localparam int QW = PW + 17;
	localparam logic [QW-1:0] RHALF = QW'(32768);
	localparam logic [PW-1:0] LIM = PW'(1) << (SW - 1);
	localparam logic signed [SW-1:0] LIM_POS = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] LIM_NEG = {1'b1, {(SW - 1){1'b0}}};

	logic [5:1] v_s;
	logic [6:1] en;

	logic signed [PW-1:0] psum [4];
	logic signed [PW-1:0] p_s1 [4];
	logic [PW-1:0]        mag_s2 [4];
	logic [PW+15:0]       prod_s3 [4];
	logic [SW-1:0]        q_s4 [4];
	logic                 sat_s4 [4];
	logic                 neg_s2 [4];
	logic                 neg_s3 [4];
	logic                 neg_s4 [4];
	logic signed [SW-1:0] wh_s5 [4];

	assign psum[0] = in_x - in_y + in_w;
	assign psum[1] = in_w - in_x - in_y;
	assign psum[2] = in_y - in_x + in_w;
	assign psum[3] = in_x + in_y + in_w;

	assign en[6] = out_ready;
	for (genvar k = 1; k <= 5; k++) begin : g_en
		assign en[k] = !v_s[k] || en[k+1];
	end
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1]) v_s[1] <= in_valid;
			for (int k = 2; k <= 5; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_lane
		logic [QW-1:0] rsum;
		logic [PW-1:0] q;
		assign rsum = {1'b0, prod_s3[k]} + RHALF;
		assign q    = rsum[16 +: PW];

		always_ff @(posedge clk) begin
			if (en[1]) begin
				p_s1[k] <= psum[k];
			end
			if (en[2]) begin
				mag_s2[k] <= p_s1[k][PW-1] ? PW'(-p_s1[k]) : PW'(p_s1[k]);
				neg_s2[k] <= p_s1[k][PW-1];
			end
			if (en[3]) begin
				prod_s3[k] <= mag_s2[k] * cfg.wheel_factor_recip;
				neg_s3[k]  <= neg_s2[k];
			end
			if (en[4]) begin
				q_s4[k]   <= q[SW-1:0];
				sat_s4[k] <= q >= LIM;
				neg_s4[k] <= neg_s3[k];
			end
			if (en[5]) begin
				if (neg_s4[k]) begin
					wh_s5[k] <= sat_s4[k] ? LIM_NEG : -$signed(q_s4[k]);
				end else begin
					wh_s5[k] <= sat_s4[k] ? LIM_POS : $signed(q_s4[k]);
				end
			end
		end
	end

	assign out_valid  = v_s[5];
	assign out_wheel0 = wh_s5[0];
	assign out_wheel1 = wh_s5[1];
	assign out_wheel2 = wh_s5[2];
	assign out_wheel3 = wh_s5[3];

endmodule

[rtl/mecanum_frame_rotate_mix_core.sv]
// channel   | kind         | beat holds
// s_axis    | stream in    | vx_cmd, vy_cmd, rot_cmd, yaw_count
// m_axis    | stream out   | wheel0_speed .. wheel3_speed
// apb       | config port  | yaw_offset, speed_gain, turn_arm_scale, wheel_factor_recip
//
// one beat in per cycle while the output is not back-pressured, one beat out per beat in
// 43 stages: cordic 33 (input, 30 steps, two for rounding), rotation five, mixing five
// every stage moves on when it is empty or the stage after it moves, so bubbles close up
// arst_n clears all valid bits and loads the register reset values
// top level: config registers, angle difference, cordic, rotate and mix pipelines
// depends on mfrm_pkg, mfrm_cordic, mfrm_rotate, mfrm_mix and the macro header
`timescale 1ns / 1ps
`include "mecanum_frame_rotate_mix_core_macros.svh"

module mecanum_frame_rotate_mix_core #(
	parameter int SPEED_WIDTH = 16,
	parameter int ANGLE_BITS = 13,
	parameter int TRIG_FRACTION_BITS = 15,
	localparam int IN_W = ((3 * SPEED_WIDTH + 13 + 7) / 8) * 8,
	localparam int OUT_W = ((4 * SPEED_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// vx_cmd, vy_cmd, rot_cmd, yaw_count, zero fill
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// wheel0_speed, wheel1_speed, wheel2_speed, wheel3_speed, zero fill
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mfrm_pkg::*;

	localparam int SW = SPEED_WIDTH;
	localparam int TW = TRIG_FRACTION_BITS + 2;
	localparam int XW = rot_xw(SPEED_WIDTH, TRIG_FRACTION_BITS);
	localparam int WW = rot_ww(SPEED_WIDTH);

	cfg_t cfg_q;

	logic [31:0]           yaw_ext, off_ext, diff_ext;
	logic [ANGLE_BITS-1:0] angle;

	logic                 c_valid, c_ready;
	logic signed [TW-1:0] c_cos, c_sin;
	logic [3*SW-1:0]      c_side;

	logic                 r_valid, r_ready;
	logic signed [XW-1:0] r_x, r_y;
	logic signed [WW-1:0] r_w;

	logic signed [SW-1:0] wh0, wh1, wh2, wh3;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.yaw_offset         <= RST_YAW_OFFSET;
			cfg_q.speed_gain         <= RST_SPEED_GAIN;
			cfg_q.turn_arm_scale     <= RST_TURN_ARM;
			cfg_q.wheel_factor_recip <= RST_WHEEL_RECIP;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_YAW_OFFSET:  cfg_q.yaw_offset         <= pwdata[12:0];
				REG_SPEED_GAIN:  cfg_q.speed_gain         <= pwdata[3:0];
				REG_TURN_ARM:    cfg_q.turn_arm_scale     <= pwdata[15:0];
				REG_WHEEL_RECIP: cfg_q.wheel_factor_recip <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_YAW_OFFSET:  prdata = 32'(cfg_q.yaw_offset);
			REG_SPEED_GAIN:  prdata = 32'(cfg_q.speed_gain);
			REG_TURN_ARM:    prdata = 32'(cfg_q.turn_arm_scale);
			REG_WHEEL_RECIP: prdata = 32'(cfg_q.wheel_factor_recip);
			default:         prdata = '0;
		endcase
	end

	// angle wraps modulo 2^ANGLE_BITS
	assign yaw_ext  = 32'(s_axis_tdata[3*SW +: 13]);
	assign off_ext  = 32'(cfg_q.yaw_offset);
	assign diff_ext = yaw_ext - off_ext;
	assign angle    = diff_ext[ANGLE_BITS-1:0];

	mfrm_cordic #(
		.ANGLE_BITS(ANGLE_BITS),
		.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS),
		.SIDE_W(3 * SW)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_angle (angle),
		.in_side  (s_axis_tdata[3*SW-1:0]),
		.out_valid(c_valid),
		.out_ready(c_ready),
		.out_cos  (c_cos),
		.out_sin  (c_sin),
		.out_side (c_side)
	);

	mfrm_rotate #(
		.SPEED_WIDTH(SPEED_WIDTH),
		.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
	) u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (c_valid),
		.in_ready (c_ready),
		.in_cos   (c_cos),
		.in_sin   (c_sin),
		.in_side  (c_side),
		.out_valid(r_valid),
		.out_ready(r_ready),
		.out_x    (r_x),
		.out_y    (r_y),
		.out_w    (r_w)
	);

	mfrm_mix #(
		.SPEED_WIDTH(SPEED_WIDTH),
		.XW(XW),
		.WW(WW)
	) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (r_valid),
		.in_ready  (r_ready),
		.in_x      (r_x),
		.in_y      (r_y),
		.in_w      (r_w),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_wheel0(wh0),
		.out_wheel1(wh1),
		.out_wheel2(wh2),
		.out_wheel3(wh3)
	);

	assign m_axis_tdata = OUT_W'({wh3, wh2, wh1, wh0});

	`MFRM_ASSERT(a_ready_when_drained, (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
	`MFRM_ASSERT_NEXT(a_gain_write, psel && penable && pwrite && reg_idx_t'(paddr[3:2]) == REG_SPEED_GAIN, cfg_q.speed_gain == $past(pwdata[3:0]))
	`MFRM_ASSERT_NEXT(a_offset_write, psel && penable && pwrite && reg_idx_t'(paddr[3:2]) == REG_YAW_OFFSET, cfg_q.yaw_offset == $past(pwdata[12:0]))

endmodule
